// ===== sv/sdhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SD host sequencer package
// Shared types, codes and constants of the SPI-mode SD card host sequencer.
// ----------------------------------------------------------------------------
package sdhs_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam int JOB_DEPTH_DEF = 2;
	localparam int RES_DEPTH_DEF = 2;

	// Input opcodes.
	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_READ = 2'd1;
	localparam logic [1:0] OP_BYTE = 2'd2;
	localparam logic [1:0] OP_TICK = 2'd3;

	// Result actions.
	localparam logic [2:0] ACT_CS = 3'd0;
	localparam logic [2:0] ACT_SEND = 3'd1;
	localparam logic [2:0] ACT_RECV = 3'd2;
	localparam logic [2:0] ACT_WAIT = 3'd3;
	localparam logic [2:0] ACT_DATA = 3'd4;
	localparam logic [2:0] ACT_DONE = 3'd5;

	// Final status codes.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_CMD0 = 3'd1;
	localparam logic [2:0] ST_CMD8_MISMATCH = 3'd2;
	localparam logic [2:0] ST_CMD8_ERR = 3'd3;
	localparam logic [2:0] ST_ACMD41_TO = 3'd4;
	localparam logic [2:0] ST_CMD58 = 3'd5;
	localparam logic [2:0] ST_CMD17 = 3'd6;
	localparam logic [2:0] ST_TOKEN = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] REG_IDLE_CLK = 2'd0;
	localparam logic [1:0] REG_RESP_TRIES = 2'd1;
	localparam logic [1:0] REG_RETRY_LIM = 2'd2;
	localparam logic [1:0] REG_TOKEN_TO = 2'd3;

	localparam logic [5:0] CMD_GO_IDLE = 6'd0;
	localparam logic [5:0] CMD_IF_COND = 6'd8;
	localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
	localparam logic [5:0] CMD_SEND_OP = 6'd41;
	localparam logic [5:0] CMD_APP = 6'd55;
	localparam logic [5:0] CMD_READ_OCR = 6'd58;

	localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
	localparam logic [31:0] ARG_HCS = 32'h4000_0000;
	localparam logic [7:0] CRC_CMD0 = 8'h95;
	localparam logic [7:0] CRC_CMD8 = 8'h87;
	localparam logic [7:0] CRC_DUMMY = 8'h01;
	localparam logic [7:0] TOKEN_START = 8'hFE;
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	typedef enum logic [3:0] {
		PH_IDLE, PH_IDLECLK, PH_CMD0, PH_CMD8, PH_R7, PH_CMD55, PH_CMD41,
		PH_TICK, PH_CMD58, PH_OCR, PH_CMD17, PH_TOKEN, PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		TL_NONE, TL_RECV, TL_WAIT, TL_FINISH, TL_CLOSE_FINISH
	} tail_t;

	typedef enum logic [2:0] {
		SG_CS0, SG_DATA, SG_FF, SG_FRAME, SG_TAIL
	} seg_t;

	// One classified request: the list of host actions it causes.
	typedef struct packed {
		logic        lead_cs0;
		logic        has_data;
		logic [7:0]  data_b;
		logic [8:0]  data_i;
		logic [4:0]  ff_n;
		logic        frame;
		logic [5:0]  cmd;
		logic [31:0] arg;
		logic [7:0]  crc;
		tail_t       tail;
		logic [2:0]  status;
		logic [7:0]  last_resp;
		logic        hc;
	} job_t;

	typedef struct packed {
		logic [2:0] action;
		logic       select_active;
		logic [7:0] send_byte;
		logic [7:0] data_byte;
		logic [8:0] data_index;
		logic [2:0] status;
		logic [7:0] last_response;
		logic       high_capacity;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [7:0]  idle_clks;
		logic [7:0]  resp_tries;
		logic [15:0] retry_lim;
		logic [15:0] token_to;
	} cfg_t;

endpackage
`default_nettype wire

// ===== sv/sdhs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SD host sequencer queue
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module sdhs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             rd,
	output logic                  full,
	output logic                  empty,
	output logic [WIDTH-1:0]      rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LASTP = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic do_wr, do_rd;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LASTP) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == LASTP) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/sdhs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SD host sequencer front end
// Holds the protocol state and turns each request into at most one job.
// ----------------------------------------------------------------------------
module sdhs_front import sdhs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] sector_number,
	input  wire logic [7:0]  received_byte,
	input  wire cfg_t        cfg,
	output logic             job_wr,
	output job_t             job
);
	phase_t      phase_q, phase_n;
	logic [15:0] att_q, att_n;
	logic [7:0]  rtry_q, rtry_n;
	logic [15:0] bc_q, bc_n;
	logic        blk_q, blk_n;
	logic [7:0]  sresp_q, sresp_n;
	logic [7:0]  tr_q [4];
	logic        tr_we;

	always_comb begin
		logic [7:0]  b;
		logic [7:0]  rlim;
		logic [15:0] ilim, tlim;
		logic        r1_done;
		logic [7:0]  r1_val;
		logic [15:0] bcv;
		job_t        j;
		logic        do_idle;

		b = received_byte;
		rlim = (cfg.resp_tries == '0) ? 8'd1 : cfg.resp_tries;
		ilim = (cfg.retry_lim == '0) ? 16'd1 : cfg.retry_lim;
		tlim = (cfg.token_to == '0) ? 16'd1 : cfg.token_to;
		r1_done = !b[7] || ((rtry_q + 8'd1) >= rlim);
		r1_val = b[7] ? FILL_BYTE : b;

		phase_n = phase_q;
		att_n = att_q;
		rtry_n = rtry_q;
		bc_n = bc_q;
		blk_n = blk_q;
		sresp_n = sresp_q;
		tr_we = 1'b0;
		j = '0;
		j.tail = TL_NONE;
		do_idle = 1'b0;
		bcv = bc_q;

		if (in_valid) begin
			unique case (opcode)
				OP_INIT: begin
					if (phase_q == PH_IDLE) begin
						j.lead_cs0 = 1'b1;
						bcv = {8'd0, cfg.idle_clks};
						do_idle = 1'b1;
					end
				end
				OP_READ: begin
					if (phase_q == PH_IDLE) begin
						j.frame = 1'b1;
						j.cmd = CMD_READ_SINGLE;
						j.arg = blk_q ? sector_number : {sector_number[22:0], 9'd0};
						j.crc = CRC_DUMMY;
						rtry_n = '0;
						phase_n = PH_CMD17;
					end
				end
				OP_TICK: begin
					if (phase_q == PH_TICK) begin
						if (att_q >= ilim) begin
							j.tail = TL_FINISH;
							j.status = ST_ACMD41_TO;
							phase_n = PH_IDLE;
						end else begin
							j.frame = 1'b1;
							j.cmd = CMD_APP;
							j.crc = CRC_DUMMY;
							rtry_n = '0;
							phase_n = PH_CMD55;
						end
					end
				end
				OP_BYTE: begin
					// Stages that wait for an R1 byte share the retry logic.
					if ((phase_q == PH_CMD0 || phase_q == PH_CMD8 || phase_q == PH_CMD55 ||
					     phase_q == PH_CMD41 || phase_q == PH_CMD58 ||
					     phase_q == PH_CMD17) && !r1_done) begin
						rtry_n = rtry_q + 8'd1;
						j.tail = TL_RECV;
					end else begin
						priority case (phase_q)
							PH_IDLECLK: do_idle = 1'b1;
							PH_CMD0: begin
								sresp_n = r1_val;
								if (r1_val != 8'h01) begin
									j.tail = TL_FINISH;
									j.status = ST_CMD0;
									phase_n = PH_IDLE;
								end else begin
									j.frame = 1'b1;
									j.cmd = CMD_IF_COND;
									j.arg = ARG_IF_COND;
									j.crc = CRC_CMD8;
									rtry_n = '0;
									phase_n = PH_CMD8;
								end
							end
							PH_CMD8: begin
								sresp_n = r1_val;
								if (r1_val == 8'h01) begin
									bc_n = '0;
									j.tail = TL_RECV;
									phase_n = PH_R7;
								end else if (r1_val[2]) begin
									att_n = '0;
									j.frame = 1'b1;
									j.cmd = CMD_APP;
									j.crc = CRC_DUMMY;
									rtry_n = '0;
									phase_n = PH_CMD55;
								end else begin
									j.tail = TL_FINISH;
									j.status = ST_CMD8_ERR;
									phase_n = PH_IDLE;
								end
							end
							PH_R7: begin
								tr_we = 1'b1;
								bc_n = bc_q + 16'd1;
								if (bc_q < 16'd3) begin
									j.tail = TL_RECV;
								end else if (tr_q[2] != 8'h01 || b != 8'hAA) begin
									j.tail = TL_FINISH;
									j.status = ST_CMD8_MISMATCH;
									phase_n = PH_IDLE;
								end else begin
									att_n = '0;
									j.frame = 1'b1;
									j.cmd = CMD_APP;
									j.crc = CRC_DUMMY;
									rtry_n = '0;
									phase_n = PH_CMD55;
								end
							end
							PH_CMD55: begin
								sresp_n = r1_val;
								j.frame = 1'b1;
								j.cmd = CMD_SEND_OP;
								j.arg = ARG_HCS;
								j.crc = CRC_DUMMY;
								rtry_n = '0;
								phase_n = PH_CMD41;
							end
							PH_CMD41: begin
								sresp_n = r1_val;
								if (r1_val == 8'h00) begin
									j.frame = 1'b1;
									j.cmd = CMD_READ_OCR;
									j.crc = CRC_DUMMY;
									rtry_n = '0;
									phase_n = PH_CMD58;
								end else begin
									if (att_q != 16'hFFFF) begin
										att_n = att_q + 16'd1;
									end
									j.tail = TL_WAIT;
									phase_n = PH_TICK;
								end
							end
							PH_CMD58: begin
								sresp_n = r1_val;
								if (r1_val != 8'h00) begin
									j.tail = TL_FINISH;
									j.status = ST_CMD58;
									phase_n = PH_IDLE;
								end else begin
									bc_n = '0;
									j.tail = TL_RECV;
									phase_n = PH_OCR;
								end
							end
							PH_OCR: begin
								tr_we = 1'b1;
								bc_n = bc_q + 16'd1;
								if (bc_q < 16'd3) begin
									j.tail = TL_RECV;
								end else begin
									blk_n = tr_q[0][6];
									j.tail = TL_CLOSE_FINISH;
									j.status = ST_OK;
									phase_n = PH_IDLE;
								end
							end
							PH_CMD17: begin
								sresp_n = r1_val;
								if (r1_val != 8'h00) begin
									j.tail = TL_FINISH;
									j.status = ST_CMD17;
									phase_n = PH_IDLE;
								end else begin
									att_n = '0;
									j.tail = TL_RECV;
									phase_n = PH_TOKEN;
								end
							end
							PH_TOKEN: begin
								if (b == TOKEN_START) begin
									bc_n = '0;
									j.tail = TL_RECV;
									phase_n = PH_DATA;
								end else if (b != FILL_BYTE ||
								             (att_q + 16'd1) >= tlim) begin
									att_n = att_q + 16'd1;
									j.tail = TL_FINISH;
									j.status = ST_TOKEN;
									phase_n = PH_IDLE;
								end else begin
									att_n = att_q + 16'd1;
									j.tail = TL_RECV;
								end
							end
							PH_DATA: begin
								bc_n = bc_q + 16'd1;
								if (bc_q < 16'(SECTOR_BYTES)) begin
									j.has_data = 1'b1;
									j.data_b = b;
									j.data_i = bc_q[8:0];
									j.tail = TL_RECV;
								end else if (bc_q + 16'd1 < 16'(SECTOR_BYTES + 2)) begin
									j.tail = TL_RECV;
								end else begin
									j.tail = TL_CLOSE_FINISH;
									j.status = ST_OK;
									phase_n = PH_IDLE;
								end
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end

		// Idle clocks go out ten at most with CMD0, otherwise in bursts of 21.
		if (do_idle) begin
			if (bcv <= 16'd10) begin
				j.ff_n = bcv[4:0];
				bc_n = '0;
				j.frame = 1'b1;
				j.cmd = CMD_GO_IDLE;
				j.arg = '0;
				j.crc = CRC_CMD0;
				rtry_n = '0;
				phase_n = PH_CMD0;
			end else begin
				j.ff_n = 5'd20;
				j.tail = TL_RECV;
				bc_n = bcv - 16'd21;
				phase_n = PH_IDLECLK;
			end
		end

		j.last_resp = sresp_n;
		j.hc = blk_n;
		job = j;
		job_wr = j.lead_cs0 || j.has_data || (j.ff_n != '0) || j.frame ||
		         (j.tail != TL_NONE);
	end

	always_ff @(posedge clk) begin
		if (tr_we) begin
			tr_q[bc_q[1:0]] <= received_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			att_q <= '0;
			rtry_q <= '0;
			bc_q <= '0;
			blk_q <= 1'b0;
			sresp_q <= FILL_BYTE;
		end else begin
			phase_q <= phase_n;
			att_q <= att_n;
			rtry_q <= rtry_n;
			bc_q <= bc_n;
			blk_q <= blk_n;
			sresp_q <= sresp_n;
		end
	end
endmodule
`default_nettype wire

// ===== sv/sdhs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SD host sequencer back end
// Expands each job into host actions, one per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module sdhs_back import sdhs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_empty,
	input  wire job_t job,
	output logic      job_rd,
	input  wire logic res_full,
	output logic      res_wr,
	output res_t      res
);
	seg_t       seg_q, seg_n;
	logic [4:0] cnt_q, cnt_n;

	always_comb begin
		logic [4:0] pres;
		logic [4:0] later;
		seg_t       cur;
		logic       seg_end;
		logic       is_last;
		res_t       r;

		pres = {job.tail != TL_NONE, job.frame, job.ff_n != '0, job.has_data,
		        job.lead_cs0};
		cur = SG_TAIL;
		for (int k = 4; k >= 0; k--) begin
			if (pres[k] && k >= int'(seg_q)) begin
				cur = seg_t'(k);
			end
		end
		later = '0;
		for (int k = 0; k < 5; k++) begin
			later[k] = pres[k] && (k > int'(cur));
		end

		r = '0;
		seg_end = 1'b1;
		unique case (cur)
			SG_CS0: r.action = ACT_CS;
			SG_DATA: begin
				r.action = ACT_DATA;
				r.data_byte = job.data_b;
				r.data_index = job.data_i;
			end
			SG_FF: begin
				r.action = ACT_SEND;
				r.send_byte = FILL_BYTE;
				seg_end = (cnt_q == job.ff_n - 5'd1);
			end
			SG_FRAME: begin
				seg_end = (cnt_q == 5'd10);
				r.action = ACT_SEND;
				unique case (cnt_q)
					5'd0: r.action = ACT_CS;
					5'd2: begin
						r.action = ACT_CS;
						r.select_active = 1'b1;
					end
					5'd4: r.send_byte = {2'b01, job.cmd};
					5'd5: r.send_byte = job.arg[31:24];
					5'd6: r.send_byte = job.arg[23:16];
					5'd7: r.send_byte = job.arg[15:8];
					5'd8: r.send_byte = job.arg[7:0];
					5'd9: r.send_byte = job.crc;
					5'd10: r.action = ACT_RECV;
					default: r.send_byte = FILL_BYTE;
				endcase
			end
			SG_TAIL: begin
				unique case (job.tail)
					TL_RECV: r.action = ACT_RECV;
					TL_WAIT: r.action = ACT_WAIT;
					TL_CLOSE_FINISH: begin
						seg_end = (cnt_q == 5'd2);
						if (cnt_q == 5'd0) begin
							r.action = ACT_CS;
						end else if (cnt_q == 5'd1) begin
							r.action = ACT_SEND;
							r.send_byte = FILL_BYTE;
						end else begin
							r.action = ACT_DONE;
						end
					end
					default: r.action = ACT_DONE;
				endcase
			end
			default: ;
		endcase
		if (r.action == ACT_DONE) begin
			r.status = job.status;
			r.last_response = job.last_resp;
			r.high_capacity = job.hc;
		end
		is_last = seg_end && (later == '0);
		r.last = is_last;
		res = r;

		res_wr = !job_empty && !res_full;
		job_rd = res_wr && is_last;
		seg_n = seg_q;
		cnt_n = cnt_q;
		if (res_wr) begin
			if (is_last) begin
				seg_n = SG_CS0;
				cnt_n = '0;
			end else if (seg_end) begin
				seg_n = seg_t'(cur + 3'd1);
				cnt_n = '0;
			end else begin
				seg_n = cur;
				cnt_n = cnt_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SG_CS0;
			cnt_q <= '0;
		end else begin
			seg_q <= seg_n;
			cnt_q <= cnt_n;
		end
	end
endmodule
`default_nettype wire

// ===== sv/sd_card_spi_host_sequencer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A request's job is registered in the job queue on acceptance; the back then writes
// its first action into the result queue, from which it can be popped.
// The front takes one request per cycle while the job queue has room; the back writes
// one action per cycle while the result queue has room. A request causes 0 to 22
// actions (typically 1 for a received byte, 11 to 22 for a command frame).
// Reset: asynchronous, active low; clears phase, counters and queues, and loads the
// register defaults (10, 10, 10000, 60000). Saved response resets to 0xFF.
// ----------------------------------------------------------------------------
// SD card SPI host sequencer
// Runs SPI-mode SD card init and single-sector reads as a stream of host actions.
// ----------------------------------------------------------------------------
module sd_card_spi_host_sequencer_unit import sdhs_pkg::*; #(
	parameter int JOB_DEPTH = JOB_DEPTH_DEF,
	parameter int RES_DEPTH = RES_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request queue side.
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  opcode,
	input  wire logic [31:0] sector_number,
	input  wire logic [7:0]  received_byte,
	// Result queue side.
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       action,
	output logic             select_active,
	output logic [7:0]       send_byte,
	output logic [7:0]       data_byte,
	output logic [8:0]       data_index,
	output logic [2:0]       status,
	output logic [7:0]       last_response,
	output logic             high_capacity,
	output logic             last,
	// Configuration port.
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	cfg_t cfg_q;
	logic job_wr, job_rd, job_full, job_empty;
	job_t job_in, job_out;
	logic res_wr, res_full;
	res_t res_in, res_out;

	// Registers sit at byte addresses 0, 4, 8 and 12; the low address bits are
	// not decoded.
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_IDLE_CLK:   prdata = {24'd0, cfg_q.idle_clks};
			REG_RESP_TRIES: prdata = {24'd0, cfg_q.resp_tries};
			REG_RETRY_LIM:  prdata = {16'd0, cfg_q.retry_lim};
			REG_TOKEN_TO:   prdata = {16'd0, cfg_q.token_to};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_clks <= 8'd10;
			cfg_q.resp_tries <= 8'd10;
			cfg_q.retry_lim <= 16'd10000;
			cfg_q.token_to <= 16'd60000;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_IDLE_CLK:   cfg_q.idle_clks <= pwdata[7:0];
				REG_RESP_TRIES: cfg_q.resp_tries <= pwdata[7:0];
				REG_RETRY_LIM:  cfg_q.retry_lim <= pwdata[15:0];
				REG_TOKEN_TO:   cfg_q.token_to <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// The front accepts a request whenever the job queue has room. It updates
	// the protocol state at once and queues only requests that cause actions;
	// stray bytes and ticks vanish here.
	assign full = job_full;

	sdhs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (push && !job_full),
		.opcode        (opcode),
		.sector_number (sector_number),
		.received_byte (received_byte),
		.cfg           (cfg_q),
		.job_wr        (job_wr),
		.job           (job_in)
	);

	sdhs_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wdata  (job_in),
		.rd     (job_rd),
		.full   (job_full),
		.empty  (job_empty),
		.rdata  (job_out)
	);

	// The back walks the head job one action per cycle into the result queue while it has room.
	sdhs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_rd    (job_rd),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res       (res_in)
	);

	sdhs_fifo #(.WIDTH($bits(res_t)), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_in),
		.rd     (pop),
		.full   (res_full),
		.empty  (empty),
		.rdata  (res_out)
	);

	assign action = res_out.action;
	assign select_active = res_out.select_active;
	assign send_byte = res_out.send_byte;
	assign data_byte = res_out.data_byte;
	assign data_index = res_out.data_index;
	assign status = res_out.status;
	assign last_response = res_out.last_response;
	assign high_capacity = res_out.high_capacity;
	assign last = res_out.last;
endmodule
`default_nettype wire
